FILE: design/lsfq_pkg.sv
// shared types and constants for the nine-bit link step and frame queue
// no dependencies; imported by every design file but lsfq_mem
package lsfq_pkg;

    localparam int QUEUE_SLOTS_DEF = 4;
    localparam int SLOT_BYTES_DEF  = 32;
    localparam int MAX_POP_BYTES   = 32;   // most bytes one pop returns
    localparam int LEN_OFFSET      = 2;    // position of the length byte in a frame
    localparam int LEN_EXTRA       = 4;    // header and trailer bytes around the body

    localparam int POSITION_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // register map, index of each register
    localparam logic REG_NODE_NUMBER   = 1'b0;
    localparam logic REG_STREAM_ENABLE = 1'b1;

    // request kinds
    localparam logic ACTION_WORD = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    // node addresses that own a bit pair in a stream byte
    localparam logic [2:0] NODE_1 = 3'd1;
    localparam logic [2:0] NODE_2 = 3'd2;
    localparam logic [2:0] NODE_3 = 3'd3;
    localparam logic [2:0] NODE_4 = 3'd4;

    localparam logic [2:0] NODE_RESET = NODE_1;

    typedef struct packed {
        logic                  step_pulse;
        logic                  direction;
        logic                  direction_changed;
        logic [POSITION_W-1:0] position;
    } step_status_t;

    typedef struct packed {
        logic committed;
        logic dropped;
        logic empty;
    } cmd_status_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] pbyte;
    } pop_stage_t;

endpackage

FILE: design/lsfq_mem.sv
// packet byte store: one write port, one read port, registered read data
// depends on nothing; used by lsfq_queue
module lsfq_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/lsfq_step.sv
// step and direction decode with the wrapping step position
// depends on lsfq_pkg
module lsfq_step
    import lsfq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         upd,
    input  logic [2:0]   node_number,
    input  logic [7:0]   data_byte,
    output step_status_t cur,
    output step_status_t nxt
);

    logic                  dir_reg;
    logic                  dir_next;
    logic [POSITION_W-1:0] pos_reg;
    logic [POSITION_W-1:0] pos_next;
    logic                  step_req;

    // pick this node's bit pair, none for an unknown node
    always_comb
    begin
        case (node_number)
            NODE_1:  begin step_req = data_byte[0]; dir_next = data_byte[1]; end
            NODE_2:  begin step_req = data_byte[2]; dir_next = data_byte[3]; end
            NODE_3:  begin step_req = data_byte[4]; dir_next = data_byte[5]; end
            NODE_4:  begin step_req = data_byte[6]; dir_next = data_byte[7]; end
            default: begin step_req = 1'b0;         dir_next = 1'b0;         end
        endcase
    end

    always_comb
    begin
        if (!step_req)
        begin
            pos_next = pos_reg;
        end
        else if (dir_next)
        begin
            pos_next = pos_reg + POSITION_W'(1);
        end
        else
        begin
            pos_next = pos_reg - POSITION_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= 1'b0;
            pos_reg <= '0;
        end
        else if (upd)
        begin
            dir_reg <= dir_next;
            pos_reg <= pos_next;
        end
    end

    assign cur.step_pulse        = 1'b0;
    assign cur.direction         = dir_reg;
    assign cur.direction_changed = 1'b0;
    assign cur.position          = pos_reg;

    assign nxt.step_pulse        = step_req;
    assign nxt.direction         = dir_next;
    assign nxt.direction_changed = dir_next ^ dir_reg;
    assign nxt.position          = pos_next;

endmodule

FILE: design/lsfq_queue.sv
// packet queue: frame assembly into the byte store, commit and pop read-out
// depends on lsfq_pkg and lsfq_mem
module lsfq_queue
    import lsfq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
    parameter int SLOT_BYTES  = SLOT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        action,
    input  logic        mark_bit,
    input  logic [7:0]  data_byte,
    input  logic        out_free,
    output cmd_status_t cmd,
    output pop_stage_t  pop,
    output logic        busy
);

    localparam int DEPTH   = QUEUE_SLOTS * SLOT_BYTES;
    localparam int AW      = $clog2(DEPTH);
    localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
    localparam int CNT_W   = $clog2(SLOT_BYTES + 1);
    localparam int POP_MAX = (SLOT_BYTES < MAX_POP_BYTES) ? SLOT_BYTES : MAX_POP_BYTES;
    localparam int POP_W   = $clog2(POP_MAX + 1);
    localparam int CMP_W   = 9;

    logic [SLOT_W-1:0] write_slot_reg;
    logic [SLOT_W-1:0] read_slot_reg;
    logic              in_frame_reg;
    logic [CNT_W-1:0]  byte_count_reg;
    logic [7:0]        len_byte_reg;
    logic [CNT_W-1:0]  lengths_reg [QUEUE_SLOTS];

    logic              pop_active_reg;
    logic [AW-1:0]     pop_addr_reg;
    logic [POP_W-1:0]  pop_left_reg;
    logic              s1_valid_reg;
    logic              s1_last_reg;

    logic [SLOT_W-1:0] write_slot_inc;
    logic [SLOT_W-1:0] read_slot_inc;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  cnt_base;
    logic              store;
    logic [CNT_W-1:0]  cnt_new;
    logic [7:0]        len_now;
    logic              commit;
    logic              cmd_acc;
    logic              stream_acc;
    logic              pop_acc;
    logic [CNT_W-1:0]  len_sel;
    logic [POP_W-1:0]  pop_len;
    logic              s1_move;
    logic              issue;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_rdata;

    assign write_slot_inc = (write_slot_reg == SLOT_W'(QUEUE_SLOTS - 1)) ?
                            '0 : write_slot_reg + SLOT_W'(1);
    assign read_slot_inc  = (read_slot_reg == SLOT_W'(QUEUE_SLOTS - 1)) ?
                            '0 : read_slot_reg + SLOT_W'(1);
    assign full  = (write_slot_inc == read_slot_reg);
    assign empty = (write_slot_reg == read_slot_reg);

    // frame assembly for a command byte
    assign cnt_base = in_frame_reg ? byte_count_reg : '0;
    assign store    = (cnt_base < CNT_W'(SLOT_BYTES));
    assign cnt_new  = store ? cnt_base + CNT_W'(1) : cnt_base;
    assign len_now  = (store && (cnt_base == CNT_W'(LEN_OFFSET))) ? data_byte : len_byte_reg;
    assign commit   = (cnt_new >= CNT_W'(LEN_EXTRA)) &&
                      (CMP_W'(cnt_new) == CMP_W'(len_now) + CMP_W'(LEN_EXTRA));

    assign cmd_acc    = accept && (action == ACTION_WORD) && mark_bit && !full;
    assign stream_acc = accept && (action == ACTION_WORD) && !mark_bit;
    assign pop_acc    = accept && (action == ACTION_POP) && !empty;

    assign mem_we    = cmd_acc && store;
    assign mem_waddr = AW'(write_slot_reg) * AW'(SLOT_BYTES) + AW'(cnt_base);

    // read-out length, clipped to what one pop returns
    assign len_sel = lengths_reg[read_slot_reg];
    assign pop_len = (len_sel > CNT_W'(POP_MAX)) ? POP_W'(POP_MAX) : POP_W'(len_sel);

    // read pipeline: issue, then read data waits in the store's output register
    assign s1_move = s1_valid_reg && out_free;
    assign issue   = pop_active_reg && (!s1_valid_reg || s1_move);

    lsfq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_byte),
        .re    (issue),
        .raddr (pop_addr_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            in_frame_reg   <= 1'b0;
            byte_count_reg <= '0;
            pop_active_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_acc)
            begin
                if (commit)
                begin
                    write_slot_reg <= write_slot_inc;
                    in_frame_reg   <= 1'b0;
                end
                else
                begin
                    in_frame_reg <= 1'b1;
                end
                byte_count_reg <= cnt_new;
            end
            else if (stream_acc)
            begin
                in_frame_reg <= 1'b0;
            end

            if (pop_acc)
            begin
                read_slot_reg  <= read_slot_inc;
                pop_active_reg <= 1'b1;
            end
            else if (issue && (pop_left_reg == POP_W'(1)))
            begin
                pop_active_reg <= 1'b0;
            end

            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            len_byte_reg <= len_now;
            if (commit)
            begin
                lengths_reg[write_slot_reg] <= cnt_new;
            end
        end
        if (pop_acc)
        begin
            pop_addr_reg <= AW'(read_slot_reg) * AW'(SLOT_BYTES);
            pop_left_reg <= pop_len;
        end
        else if (issue)
        begin
            pop_addr_reg <= pop_addr_reg + AW'(1);
            pop_left_reg <= pop_left_reg - POP_W'(1);
        end
        if (issue)
        begin
            s1_last_reg <= (pop_left_reg == POP_W'(1));
        end
    end

    assign cmd.committed = commit;
    assign cmd.dropped   = full;
    assign cmd.empty     = empty;

    assign pop.valid = s1_valid_reg;
    assign pop.last  = s1_last_reg;
    assign pop.pbyte = mem_rdata;

    assign busy = pop_active_reg || s1_valid_reg;

endmodule

FILE: design/nine_bit_link_step_and_frame_queue.sv
// top level of the nine-bit link node: step decode, packet queue, result register
// depends on lsfq_pkg, lsfq_step, lsfq_queue (and through it lsfq_mem)
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------------
//  in       in_valid / in_stall    action, mark_bit, data_byte
//  out      out_valid / out_stall  step_pulse, direction, direction_changed,
//                                  position, packet_committed, byte_dropped,
//                                  packet_byte, packet_valid, queue_empty, last
//  cfg      apb psel / penable     paddr, pwdata, prdata, pready (always high)
//
// a link word or a pop on an empty queue gives a single result, in the result register
// after the accepting edge; the next request may follow at once if the result is taken
// a pop of n bytes streams one byte per cycle unless stalled, via the store's read port
// and result register; the next request waits for the last byte to leave the read stage
// reset clears the slot pointers, frame state, direction and position; the byte store
// and length table are not cleared, only committed slots are ever read
// a stalled result holds in the result register and stalls the read stage and the input
module nine_bit_link_step_and_frame_queue
    import lsfq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
    parameter int SLOT_BYTES  = SLOT_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready,

    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic                         mark_bit,
    input  logic [7:0]                   data_byte,

    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         step_pulse,
    output logic                         direction,
    output logic                         direction_changed,
    output logic signed [POSITION_W-1:0] position,
    output logic                         packet_committed,
    output logic                         byte_dropped,
    output logic [7:0]                   packet_byte,
    output logic                         packet_valid,
    output logic                         queue_empty,
    output logic                         last
);

    // configuration registers
    logic [2:0]   node_number_reg;
    logic         stream_enable_reg;
    logic         cfg_write;

    // result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  step_pulse_reg;
    logic                  direction_reg;
    logic                  direction_changed_reg;
    logic [POSITION_W-1:0] position_reg;
    logic                  packet_committed_reg;
    logic                  byte_dropped_reg;
    logic [7:0]            packet_byte_reg;
    logic                  packet_valid_reg;
    logic                  queue_empty_reg;
    logic                  last_reg;

    logic         out_free;
    logic         accept;
    logic         is_pop;
    logic         is_cmd;
    logic         is_stream;
    logic         stream_live;
    logic         load_item;
    logic         load_pop;
    logic         busy;
    step_status_t step_cur;
    step_status_t step_nxt;
    step_status_t step_sel;
    cmd_status_t  cmd;
    pop_stage_t   pop;

    // ---------------------------------------------------------------------
    // configuration: two registers, one per word, selected by paddr[2]
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_number_reg   <= NODE_RESET;
            stream_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_NODE_NUMBER:   node_number_reg   <= pwdata[2:0];
                REG_STREAM_ENABLE: stream_enable_reg <= pwdata[0];
                default:           node_number_reg   <= node_number_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_NODE_NUMBER:   prdata = CFG_DATA_W'(node_number_reg);
            REG_STREAM_ENABLE: prdata = CFG_DATA_W'(stream_enable_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // request decode and flow control
    // ---------------------------------------------------------------------
    // result register frees when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = busy || !out_free;
    assign accept   = in_valid && !in_stall;

    assign is_pop      = (action == ACTION_POP);
    assign is_cmd      = !is_pop && mark_bit;
    assign is_stream   = !is_pop && !mark_bit;
    assign stream_live = is_stream && stream_enable_reg;

    // ---------------------------------------------------------------------
    // step and direction tracking
    // ---------------------------------------------------------------------
    lsfq_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (accept && stream_live),
        .node_number (node_number_reg),
        .data_byte   (data_byte),
        .cur         (step_cur),
        .nxt         (step_nxt)
    );

    // ---------------------------------------------------------------------
    // packet queue with the byte store
    // ---------------------------------------------------------------------
    lsfq_queue #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .mark_bit  (mark_bit),
        .data_byte (data_byte),
        .out_free  (out_free),
        .cmd       (cmd),
        .pop       (pop),
        .busy      (busy)
    );

    // ---------------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------------
    // a pop on a non-empty queue gives nothing at once, its bytes follow
    assign load_item = accept && !(is_pop && !cmd.empty);
    assign load_pop  = pop.valid && out_free;

    assign step_sel = stream_live ? step_nxt : step_cur;

    always_comb
    begin
        if (load_item || load_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            step_pulse_reg        <= step_sel.step_pulse;
            direction_reg         <= step_sel.direction;
            direction_changed_reg <= step_sel.direction_changed;
            position_reg          <= step_sel.position;
            packet_committed_reg  <= is_cmd && !cmd.dropped && cmd.committed;
            byte_dropped_reg      <= is_cmd && cmd.dropped;
            packet_byte_reg       <= '0;
            packet_valid_reg      <= 1'b0;
            queue_empty_reg       <= is_pop && cmd.empty;
            last_reg              <= 1'b1;
        end
        else if (load_pop)
        begin
            step_pulse_reg        <= 1'b0;
            direction_reg         <= step_cur.direction;
            direction_changed_reg <= 1'b0;
            position_reg          <= step_cur.position;
            packet_committed_reg  <= 1'b0;
            byte_dropped_reg      <= 1'b0;
            packet_byte_reg       <= pop.pbyte;
            packet_valid_reg      <= 1'b1;
            queue_empty_reg       <= 1'b0;
            last_reg              <= pop.last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign step_pulse        = step_pulse_reg;
    assign direction         = direction_reg;
    assign direction_changed = direction_changed_reg;
    assign position          = signed'(position_reg);
    assign packet_committed  = packet_committed_reg;
    assign byte_dropped      = byte_dropped_reg;
    assign packet_byte       = packet_byte_reg;
    assign packet_valid      = packet_valid_reg;
    assign queue_empty       = queue_empty_reg;
    assign last              = last_reg;

endmodule

FILE: sim/nine_bit_link_step_and_frame_queue_tb.sv
// testbench for the nine-bit link node: step/direction decode and command packet queue
// depends on lsfq_pkg and nine_bit_link_step_and_frame_queue; self-checking, no files read
`timescale 1ns / 1ps

module nine_bit_link_step_and_frame_queue_tb;
    import lsfq_pkg::*;

    // ninth bit of a link word
    localparam logic MARK_STREAM = 1'b0;
    localparam logic MARK_CMD    = 1'b1;

    // node addresses that own no bit pair
    localparam logic [2:0] NODE_NONE_LOW  = 3'd0;
    localparam logic [2:0] NODE_NONE_HIGH = 3'd7;

    localparam int RANDOM_REQUESTS = 24;
    localparam int CHUNK_REQUESTS  = 12;

    // one result as the block should present it
    typedef struct packed {
        logic        step_pulse;
        logic        direction;
        logic        dir_flip;
        logic [31:0] position;
        logic        committed;
        logic        dropped;
        logic [7:0]  pbyte;
        logic        pvalid;
        logic        empty;
        logic        last;
    } link_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [CFG_ADDR_W-1:0]        paddr;
    logic [CFG_DATA_W-1:0]        pwdata;
    logic [CFG_DATA_W-1:0]        prdata;
    logic                         pready;
    logic                         in_valid;
    logic                         in_stall;
    logic                         action;
    logic                         mark_bit;
    logic [7:0]                   data_byte;
    logic                         out_valid;
    logic                         out_stall;
    logic                         step_pulse;
    logic                         direction;
    logic                         direction_changed;
    logic signed [POSITION_W-1:0] position;
    logic                         packet_committed;
    logic                         byte_dropped;
    logic [7:0]                   packet_byte;
    logic                         packet_valid;
    logic                         queue_empty;
    logic                         last;

    // results still owed by the block, oldest first
    link_result_t results_due[$];

    // shadow of the node state, kept in step with every accepted request
    logic [7:0]  frame_bytes [QUEUE_SLOTS_DEF * SLOT_BYTES_DEF];
    int          frame_len   [QUEUE_SLOTS_DEF];
    int          wr_slot     = 0;
    int          rd_slot     = 0;
    logic        framing     = 1'b0;
    int          fill_count  = 0;
    logic        dir_state   = 1'b0;
    logic [31:0] step_count  = '0;
    logic [2:0]  node_addr   = NODE_RESET;
    logic        stream_on   = 1'b0;

    int   mismatch_count = 0;
    int   requests_sent  = 0;
    int   rx_hold_cycles = 0;   // one-off long hold-off picked up by the result sink
    logic tx_idle_en     = 1'b1;
    logic rx_idle_en     = 1'b1;

    nine_bit_link_step_and_frame_queue u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .mark_bit          (mark_bit),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .step_pulse        (step_pulse),
        .direction         (direction),
        .direction_changed (direction_changed),
        .position          (position),
        .packet_committed  (packet_committed),
        .byte_dropped      (byte_dropped),
        .packet_byte       (packet_byte),
        .packet_valid      (packet_valid),
        .queue_empty       (queue_empty),
        .last              (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // generous ceiling, well above the slowest legal run
    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // direction and position always reflect the state after the request
    function automatic link_result_t status_now();
        link_result_t r;
        r           = '0;
        r.direction = dir_state;
        r.position  = step_count;
        return r;
    endfunction

    // works out the results of one request and advances the shadow state
    task automatic compute_link_results(input logic act, input logic mark,
                                        input logic [7:0] val);
        link_result_t r;
        int           len;
        int           base;
        int           nxt;
        int           sh;
        logic         stp;
        logic         nd;
        if (act == ACTION_POP)
        begin
            r = status_now();
            if (wr_slot == rd_slot)
            begin
                r.empty = 1'b1;
                r.last  = 1'b1;
                results_due.push_back(r);
                return;
            end
            len = frame_len[rd_slot];
            if (len > SLOT_BYTES_DEF)
                len = SLOT_BYTES_DEF;
            if (len > MAX_POP_BYTES)
                len = MAX_POP_BYTES;
            base = rd_slot * SLOT_BYTES_DEF;
            for (int i = 0; i < len; i++)
            begin
                r.pbyte  = frame_bytes[base + i];
                r.pvalid = 1'b1;
                r.last   = (i == len - 1);
                results_due.push_back(r);
            end
            rd_slot = (rd_slot + 1) % QUEUE_SLOTS_DEF;
        end
        else if (mark == MARK_CMD)
        begin
            r    = status_now();
            nxt  = (wr_slot + 1) % QUEUE_SLOTS_DEF;
            base = wr_slot * SLOT_BYTES_DEF;
            r.last = 1'b1;
            // queue full: byte is lost, frame state untouched
            if (nxt == rd_slot)
            begin
                r.dropped = 1'b1;
                results_due.push_back(r);
                return;
            end
            if (!framing)
            begin
                framing    = 1'b1;
                fill_count = 0;
            end
            // bytes past the slot size are not kept
            if (fill_count < SLOT_BYTES_DEF)
            begin
                frame_bytes[base + fill_count] = val;
                fill_count++;
            end
            if (fill_count >= LEN_EXTRA &&
                fill_count == int'(frame_bytes[base + LEN_OFFSET]) + LEN_EXTRA)
            begin
                frame_len[wr_slot] = fill_count;
                wr_slot            = nxt;
                framing            = 1'b0;
                r.committed        = 1'b1;
            end
            results_due.push_back(r);
        end
        else
        begin
            framing = 1'b0;
            stp     = 1'b0;
            nd      = 1'b0;
            if (stream_on)
            begin
                if (node_addr >= NODE_1 && node_addr <= NODE_4)
                begin
                    sh  = 2 * (int'(node_addr) - 1);
                    stp = val[sh];
                    nd  = val[sh + 1];
                end
                r = status_now();
                if (nd != dir_state)
                begin
                    dir_state  = nd;
                    r.dir_flip = 1'b1;
                end
                if (stp)
                    step_count = dir_state ? step_count + 1 : step_count - 1;
                r.direction  = dir_state;
                r.position   = step_count;
                r.step_pulse = stp;
            end
            else
                r = status_now();
            r.last = 1'b1;
            results_due.push_back(r);
        end
    endtask

    // offers one request after a random gap and returns at its accepting edge
    task automatic issue_request(input logic act, input logic mark, input logic [7:0] val);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        compute_link_results(act, mark, val);
        in_valid  <= 1'b1;
        action    <= act;
        mark_bit  <= mark;
        data_byte <= val;
        // stall is looked at as it stood at the edge
        @(posedge clk iff !in_stall);
        requests_sent++;
    endtask

    task automatic issue_pop();
        issue_request(ACTION_POP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic issue_stream(input logic [7:0] val);
        issue_request(ACTION_WORD, MARK_STREAM, val);
    endtask

    // command bytes of one frame; the length byte sits at its fixed offset
    task automatic issue_frame(input int len_val, input int count);
        logic [7:0] b;
        for (int k = 0; k < count; k++)
        begin
            if (k == LEN_OFFSET)
                b = 8'(len_val);
            else if (k == 0 && $urandom_range(0, 1) == 1)
                b = 8'h01;
            else
                b = 8'($urandom_range(0, 255));
            issue_request(ACTION_WORD, MARK_CMD, b);
        end
    endtask

    // drops valid and waits until the block owes nothing more
    task automatic wait_results_done(input int extra);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // apb write, then read back the same register
    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        want = (idx == REG_NODE_NUMBER) ? {29'b0, value[2:0]} : {31'b0, value[0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_NODE_NUMBER)
            node_addr = value[2:0];
        else
            stream_on = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field($sformatf("register %0d readback", idx), prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [2:0] node, input logic stream);
        wait_results_done(6);
        write_register(REG_NODE_NUMBER, {29'b0, node});
        write_register(REG_STREAM_ENABLE, {31'b0, stream});
    endtask

    // pops on an empty queue, stream bytes while streaming is off, shortest frame
    task automatic test_empty_and_short_frame();
        issue_pop();
        issue_stream(8'hFF);
        issue_stream(8'h00);
        issue_request(ACTION_WORD, MARK_CMD, 8'h01);
        issue_request(ACTION_WORD, MARK_CMD, 8'hFF);
        issue_request(ACTION_WORD, MARK_CMD, 8'h00);
        issue_request(ACTION_WORD, MARK_CMD, 8'h00);
        issue_stream(8'h55);
        issue_pop();
        issue_pop();
    endtask

    // each node address that owns a bit pair and two that own none; steps wrap the position
    // through zero in both directions
    task automatic test_stream_nodes();
        logic [2:0] node;
        for (int i = 0; i < 6; i++)
        begin
            if (i < 4)
                node = 3'(int'(NODE_1) + i);
            else
                node = (i == 4) ? NODE_NONE_LOW : NODE_NONE_HIGH;
            set_config(node, 1'b1);
            issue_stream(8'h55);   // step, direction down
            issue_stream(8'hFF);   // step, direction up
            issue_stream(8'hAA);   // direction up, no step
            issue_stream(8'h00);   // direction down, no step
        end
    endtask

    // longest packet, full queue, slot overflow and a frame cut short
    task automatic test_queue_limits();
        set_config(NODE_2, 1'b1);
        issue_frame(SLOT_BYTES_DEF - LEN_EXTRA, SLOT_BYTES_DEF);
        issue_frame(0, LEN_EXTRA);
        issue_frame(5, 5 + LEN_EXTRA);
        // queue now full: these are lost
        issue_request(ACTION_WORD, MARK_CMD, 8'h00);
        issue_request(ACTION_WORD, MARK_CMD, 8'hFF);
        issue_request(ACTION_WORD, MARK_CMD, 8'h01);
        issue_pop();
        // length byte beyond the slot: storage stops, only a stream byte ends it
        issue_frame(200, SLOT_BYTES_DEF + 3);
        issue_stream(8'h3C);
        issue_frame(10, 6);
        issue_stream(8'hC3);
        issue_frame(1, 1 + LEN_EXTRA);
        repeat (4) issue_pop();
    endtask

    // long receiver hold-off with the sender running flat out, then a full pause
    task automatic test_backpressure();
        set_config(NODE_3, 1'b1);
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        rx_hold_cycles = 160;
        issue_frame(12, 12 + LEN_EXTRA);
        issue_pop();
        repeat (8) issue_stream(8'($urandom_range(0, 255)));
        issue_frame(0, LEN_EXTRA);
        issue_frame(20, 20 + LEN_EXTRA);
        issue_pop();
        issue_pop();
        // sender pauses until everything owed has come out
        wait_results_done(1);
        rx_idle_en = 1'b1;
        issue_frame(3, 3 + LEN_EXTRA);
        issue_pop();
        repeat (4) issue_stream(8'($urandom_range(0, 255)));
        tx_idle_en = 1'b1;
    endtask

    // mostly well-formed frames with random content, mixed with pops,
    // stream bytes, cut-off frames and stray command bytes
    task automatic test_random_traffic();
        int         start;
        int         chunk_end;
        int         pick;
        int         len_val;
        int         count;
        logic [2:0] node;
        start = requests_sent;
        while (requests_sent - start < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 4) == 0)
                node = 3'($urandom_range(0, 7));
            else
                node = 3'($urandom_range(int'(NODE_1), int'(NODE_4)));
            set_config(node, $urandom_range(0, 3) != 0);
            tx_idle_en = $urandom_range(0, 2) != 0;
            rx_idle_en = $urandom_range(0, 2) != 0;
            chunk_end  = requests_sent + CHUNK_REQUESTS;
            while (requests_sent < chunk_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        len_val = $urandom_range(0, 12);
                    else if (pick < 93)
                        len_val = $urandom_range(13, SLOT_BYTES_DEF - LEN_EXTRA);
                    else
                        len_val = $urandom_range(SLOT_BYTES_DEF - LEN_EXTRA + 1, 255);
                    count = len_val + LEN_EXTRA;
                    if (len_val > SLOT_BYTES_DEF - LEN_EXTRA)
                        count = $urandom_range(20, SLOT_BYTES_DEF + 6);
                    else if ($urandom_range(0, 6) == 0)
                        count = $urandom_range(1, count);
                    issue_frame(len_val, count);
                    if (count < len_val + LEN_EXTRA)
                        issue_stream(8'($urandom_range(0, 255)));
                end
                else if (pick < 75)
                    issue_pop();
                else if (pick < 92)
                    issue_stream(8'($urandom_range(0, 255)));
                else
                    issue_request(ACTION_WORD, MARK_CMD, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // result sink: random stall per result, compares each one with the oldest owed
    initial
    begin : result_sink
        int           hold;
        link_result_t want;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_idle_en ? $urandom_range(0, 15) : 0;
            hold += rx_hold_cycles;
            rx_hold_cycles = 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            // fields are read as they stood at the accepting edge
            @(posedge clk iff out_valid);
            if (results_due.size() == 0)
                report_mismatch("result with nothing owed");
            else
            begin
                want = results_due.pop_front();
                check_field("step_pulse", step_pulse, want.step_pulse);
                check_field("direction", direction, want.direction);
                check_field("direction_changed", direction_changed, want.dir_flip);
                check_field("position", position, want.position);
                check_field("packet_committed", packet_committed, want.committed);
                check_field("byte_dropped", byte_dropped, want.dropped);
                check_field("packet_byte", packet_byte, want.pbyte);
                check_field("packet_valid", packet_valid, want.pvalid);
                check_field("queue_empty", queue_empty, want.empty);
                check_field("last", last, want.last);
            end
        end
    end

    // main sequence: reset once, then each test in turn
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        action    <= ACTION_WORD;
        mark_bit  <= MARK_STREAM;
        data_byte <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_short_frame();
        test_stream_nodes();
        test_queue_limits();
        test_backpressure();
        test_random_traffic();

        // let any stray result show up before the verdict
        wait_results_done(40);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
